@@ design/lis_pkg.sv @@
// Shared types, codes and helper functions for the launch interlock sequencer.
package lis_pkg;

    localparam int TIMER_W = 16;
    localparam int COUNT_W = 5;

    localparam logic [TIMER_W-1:0] TIMER_MAX        = '1;
    localparam logic [TIMER_W-1:0] COMPLETE_WAIT_MS = 16'd1000;

    // Reset values of the configuration registers
    localparam logic [TIMER_W-1:0] HOLD_TO_LAUNCH_RST  = 16'd5000;
    localparam logic [TIMER_W-1:0] RELAY_ON_RST        = 16'd5000;
    localparam logic [TIMER_W-1:0] COOLDOWN_RST        = 16'd5000;
    localparam logic [TIMER_W-1:0] ABORT_INHIBIT_RST   = 16'd1500;
    localparam logic [TIMER_W-1:0] RESET_HOLD_RST      = 16'd2500;
    localparam logic [TIMER_W-1:0] SPLASH_RST          = 16'd5000;
    localparam logic [TIMER_W-1:0] CHECK_INTERVAL_RST  = 16'd250;
    localparam logic [TIMER_W-1:0] LAUNCH_CONFIRM_RST  = 16'd250;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_HOLD_TO_LAUNCH = 3'd0,
        CFG_RELAY_ON       = 3'd1,
        CFG_COOLDOWN       = 3'd2,
        CFG_ABORT_INHIBIT  = 3'd3,
        CFG_RESET_HOLD     = 3'd4,
        CFG_SPLASH         = 3'd5,
        CFG_CHECK_INTERVAL = 3'd6,
        CFG_LAUNCH_CONFIRM = 3'd7
    } cfg_index_t;

    // Sequencer modes
    typedef enum logic [3:0] {
        MODE_STARTUP   = 4'd0,
        MODE_SPLASH    = 4'd1,
        MODE_READY     = 4'd2,
        MODE_ARMED     = 4'd3,
        MODE_COUNTDOWN = 4'd4,
        MODE_LAUNCHING = 4'd5,
        MODE_COOLDOWN  = 4'd6,
        MODE_ABORT     = 4'd7,
        MODE_FAULT     = 4'd8
    } mode_t;

    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic               active;
    } press_t;

    typedef struct packed {
        mode_t              mode;
        logic [TIMER_W-1:0] time_in_mode;
        press_t             press;
        logic [COUNT_W-1:0] checks_done;
        logic [TIMER_W-1:0] interval_timer;
        logic               checks_complete;
        logic [TIMER_W-1:0] complete_timer;
    } seq_state_t;

    // Saturating millisecond increment
    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        return (v == TIMER_MAX) ? TIMER_MAX : v + 1'b1;
    endfunction

    // Mode entry: clears mode time and press tracking, startup also resets checks
    function automatic seq_state_t go_mode(input seq_state_t s, input mode_t m);
        seq_state_t r;
        r              = s;
        r.mode         = m;
        r.time_in_mode = '0;
        r.press        = '0;
        if (m == MODE_STARTUP) begin
            r.checks_done     = '0;
            r.interval_timer  = TIMER_MAX;
            r.checks_complete = 1'b0;
            r.complete_timer  = '0;
        end
        return r;
    endfunction

    // Press tracker: first pressed tick counts as zero
    function automatic press_t press_track(input press_t p, input logic pressed);
        press_t r;
        if (!pressed) begin
            r = '0;
        end else if (!p.active) begin
            r.active = 1'b1;
            r.timer  = '0;
        end else begin
            r.active = 1'b1;
            r.timer  = sat_inc(p.timer);
        end
        return r;
    endfunction

endpackage

@@ design/launch_interlock_sequencer.sv @@
// Launch interlock sequencer: mode state machine with timers and result register.
//
// Each input item is one millisecond tick. One item is taken per clock cycle
// while the result register is empty or being read; its result is in the output
// register in the cycle after acceptance, and the next item is taken in the same
// cycle the result leaves. A single next-state pass, state to result register,
// sets throughput. After reset it sits in splash mode. The user must write the
// eight timing registers via the write port only while idle; it is not enforced.
module launch_interlock_sequencer
    import lis_pkg::*;
#(
    parameter int CHECK_COUNT = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [TIMER_W-1:0]  cfg_wr_data,
    // tick items
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_arm_on,
    input  logic                s_reset_pressed,
    input  logic                s_launch_pressed,
    input  logic                s_global_fault,
    // result items
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_mode,
    output logic                m_ready_led,
    output logic                m_armed_led,
    output logic                m_launch_lamp,
    output logic                m_relay_drive,
    output logic                m_check_step,
    output logic [COUNT_W-1:0]  m_check_number,
    output logic                m_mode_entered
);

    localparam logic [COUNT_W-1:0] CHECK_LIMIT = COUNT_W'(CHECK_COUNT);

    // Configuration registers
    logic [TIMER_W-1:0] hold_to_launch_reg, relay_on_reg, cooldown_reg, abort_inhibit_reg;
    logic [TIMER_W-1:0] reset_hold_reg, splash_reg, check_interval_reg, launch_confirm_reg;

    seq_state_t st_reg, st_next;
    logic       entered, step;
    logic       accept;

    logic               m_valid_reg;
    logic [3:0]         m_mode_reg;
    logic               m_ready_led_reg, m_armed_led_reg, m_launch_lamp_reg;
    logic               m_relay_drive_reg, m_check_step_reg, m_mode_entered_reg;
    logic [COUNT_W-1:0] m_check_number_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_to_launch_reg <= HOLD_TO_LAUNCH_RST;
            relay_on_reg       <= RELAY_ON_RST;
            cooldown_reg       <= COOLDOWN_RST;
            abort_inhibit_reg  <= ABORT_INHIBIT_RST;
            reset_hold_reg     <= RESET_HOLD_RST;
            splash_reg         <= SPLASH_RST;
            check_interval_reg <= CHECK_INTERVAL_RST;
            launch_confirm_reg <= LAUNCH_CONFIRM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HOLD_TO_LAUNCH: hold_to_launch_reg <= cfg_wr_data;
                CFG_RELAY_ON:       relay_on_reg       <= cfg_wr_data;
                CFG_COOLDOWN:       cooldown_reg       <= cfg_wr_data;
                CFG_ABORT_INHIBIT:  abort_inhibit_reg  <= cfg_wr_data;
                CFG_RESET_HOLD:     reset_hold_reg     <= cfg_wr_data;
                CFG_SPLASH:         splash_reg         <= cfg_wr_data;
                CFG_CHECK_INTERVAL: check_interval_reg <= cfg_wr_data;
                CFG_LAUNCH_CONFIRM: launch_confirm_reg <= cfg_wr_data;
            endcase
        end
    end

    // Next-state pass for one tick
    always_comb begin
        st_next              = st_reg;
        entered              = 1'b0;
        step                 = 1'b0;
        st_next.time_in_mode = sat_inc(st_reg.time_in_mode);

        // global fault preempts every mode but fault itself
        if (st_reg.mode != MODE_FAULT && s_global_fault) begin
            st_next = go_mode(st_next, MODE_FAULT);
            entered = 1'b1;
        end

        unique case (st_next.mode)
            MODE_STARTUP: begin
                if (s_arm_on || s_reset_pressed || s_launch_pressed) begin
                    st_next = go_mode(st_next, MODE_FAULT);
                    entered = 1'b1;
                end else begin
                    st_next.interval_timer = sat_inc(st_next.interval_timer);
                    if (st_next.checks_complete) begin
                        st_next.complete_timer = sat_inc(st_next.complete_timer);
                    end
                    if (st_next.interval_timer >= check_interval_reg) begin
                        st_next.interval_timer = '0;
                        if (st_next.checks_done < CHECK_LIMIT) begin
                            st_next.checks_done = st_next.checks_done + 1'b1;
                            step                = 1'b1;
                        end else begin
                            if (!st_next.checks_complete) begin
                                st_next.checks_complete = 1'b1;
                                st_next.complete_timer  = '0;
                            end
                            if (st_next.complete_timer >= COMPLETE_WAIT_MS) begin
                                st_next = go_mode(st_next, MODE_READY);
                                entered = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_SPLASH: begin
                if (st_next.time_in_mode >= splash_reg) begin
                    st_next = go_mode(st_next, MODE_STARTUP);
                    entered = 1'b1;
                end
            end
            MODE_READY: begin
                if (s_arm_on) begin
                    st_next = go_mode(st_next, MODE_ARMED);
                    entered = 1'b1;
                end
            end
            MODE_ARMED: begin
                if (!s_arm_on) begin
                    st_next = go_mode(st_next, MODE_READY);
                    entered = 1'b1;
                end else begin
                    st_next.press = press_track(st_next.press, s_launch_pressed);
                    if (s_launch_pressed && st_next.press.timer >= launch_confirm_reg) begin
                        st_next = go_mode(st_next, MODE_COUNTDOWN);
                        entered = 1'b1;
                    end
                end
            end
            MODE_COUNTDOWN: begin
                if (!s_arm_on) begin
                    st_next = go_mode(st_next, MODE_FAULT);
                    entered = 1'b1;
                end else if (!s_launch_pressed) begin
                    st_next = go_mode(st_next, MODE_ABORT);
                    entered = 1'b1;
                end else if (st_next.time_in_mode >= hold_to_launch_reg) begin
                    st_next = go_mode(st_next, MODE_LAUNCHING);
                    entered = 1'b1;
                end
            end
            MODE_LAUNCHING: begin
                if (st_next.time_in_mode >= relay_on_reg) begin
                    st_next = go_mode(st_next, MODE_COOLDOWN);
                    entered = 1'b1;
                end
            end
            MODE_COOLDOWN: begin
                if (st_next.time_in_mode >= cooldown_reg) begin
                    st_next = go_mode(st_next, MODE_FAULT);
                    entered = 1'b1;
                end
            end
            MODE_ABORT: begin
                if (st_next.time_in_mode >= abort_inhibit_reg) begin
                    st_next = go_mode(st_next, s_arm_on ? MODE_ARMED : MODE_READY);
                    entered = 1'b1;
                end
            end
            MODE_FAULT: begin
                // recovery needs arm off and reset held, with no global fault
                if (!s_arm_on) begin
                    st_next.press = press_track(st_next.press, s_reset_pressed);
                    if (s_reset_pressed && st_next.press.timer >= reset_hold_reg
                        && !s_global_fault) begin
                        st_next = go_mode(st_next, MODE_READY);
                        entered = 1'b1;
                    end
                end else begin
                    st_next.press = '0;
                end
            end
            default: begin
                st_next = go_mode(st_next, MODE_FAULT);
                entered = 1'b1;
            end
        endcase
    end

    // State register, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= go_mode('0, MODE_SPLASH);
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_mode_reg         <= st_next.mode;
            m_ready_led_reg    <= (st_next.mode == MODE_READY);
            m_armed_led_reg    <= (st_next.mode == MODE_ARMED)
                                  || (st_next.mode == MODE_COUNTDOWN);
            m_launch_lamp_reg  <= (st_next.mode == MODE_LAUNCHING);
            m_relay_drive_reg  <= (st_next.mode == MODE_LAUNCHING);
            m_check_step_reg   <= step;
            m_check_number_reg <= st_next.checks_done;
            m_mode_entered_reg <= entered;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_mode         = m_mode_reg;
    assign m_ready_led    = m_ready_led_reg;
    assign m_armed_led    = m_armed_led_reg;
    assign m_launch_lamp  = m_launch_lamp_reg;
    assign m_relay_drive  = m_relay_drive_reg;
    assign m_check_step   = m_check_step_reg;
    assign m_check_number = m_check_number_reg;
    assign m_mode_entered = m_mode_entered_reg;

    // Checks
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no result");

    a_gfault_forces_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_global_fault) |=> (m_valid && m_mode == MODE_FAULT
                                        && !m_relay_drive))
        else $error("global fault did not force fault mode");

    a_checks_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.checks_done <= CHECK_LIMIT)
        else $error("self-check count exceeded limit");

    a_step_only_startup: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && st_reg.mode != MODE_STARTUP) |=> !m_check_step)
        else $error("check step pulse outside startup");

endmodule

@@ tb/sv/launch_sequence_checker.sv @@
// Checker for the launch interlock sequencer: mirrors the mode machine and compares result items.
module launch_sequence_checker
    import lis_pkg::*;
#(
    parameter int CHECK_COUNT = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [TIMER_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_arm_on,
    input  logic               s_reset_pressed,
    input  logic               s_launch_pressed,
    input  logic               s_global_fault,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_mode,
    input  logic               m_ready_led,
    input  logic               m_armed_led,
    input  logic               m_launch_lamp,
    input  logic               m_relay_drive,
    input  logic               m_check_step,
    input  logic [COUNT_W-1:0] m_check_number,
    input  logic               m_mode_entered,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]         mode;
        logic               ready_led;
        logic               armed_led;
        logic               launch_lamp;
        logic               relay_drive;
        logic               check_step;
        logic [COUNT_W-1:0] check_number;
        logic               mode_entered;
    } tick_result_t;

    // Local copy of the timing registers
    logic [TIMER_W-1:0] limit_ms [8];

    // Mirrored sequencer state
    mode_t              cur_mode;
    logic [TIMER_W-1:0] mode_age;
    logic [TIMER_W-1:0] press_age;
    logic               press_held;
    logic [COUNT_W-1:0] steps_shown;
    logic [TIMER_W-1:0] step_timer;
    logic               steps_finished;
    logic [TIMER_W-1:0] settle_timer;
    logic               entered_now;

    tick_result_t due_results [$];
    int           mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [TIMER_W-1:0] inc_sat(input logic [TIMER_W-1:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic clear_model();
        limit_ms[CFG_HOLD_TO_LAUNCH] = HOLD_TO_LAUNCH_RST;
        limit_ms[CFG_RELAY_ON]       = RELAY_ON_RST;
        limit_ms[CFG_COOLDOWN]       = COOLDOWN_RST;
        limit_ms[CFG_ABORT_INHIBIT]  = ABORT_INHIBIT_RST;
        limit_ms[CFG_RESET_HOLD]     = RESET_HOLD_RST;
        limit_ms[CFG_SPLASH]         = SPLASH_RST;
        limit_ms[CFG_CHECK_INTERVAL] = CHECK_INTERVAL_RST;
        limit_ms[CFG_LAUNCH_CONFIRM] = LAUNCH_CONFIRM_RST;
        cur_mode       = MODE_SPLASH;
        mode_age       = '0;
        press_age      = '0;
        press_held     = 1'b0;
        steps_shown    = '0;
        step_timer     = '0;
        steps_finished = 1'b0;
        settle_timer   = '0;
        entered_now    = 1'b0;
        due_results.delete();
    endtask

    // Mode change: restart mode time and any press; startup also restarts the checks
    task automatic enter(input mode_t m);
        cur_mode    = m;
        mode_age    = '0;
        press_held  = 1'b0;
        press_age   = '0;
        entered_now = 1'b1;
        if (m == MODE_STARTUP) begin
            steps_shown    = '0;
            step_timer     = '1;
            steps_finished = 1'b0;
            settle_timer   = '0;
        end
    endtask

    // Press duration tracking; the first pressed tick counts as zero
    task automatic track_press(input logic pressed, input logic [TIMER_W-1:0] need,
                               output logic reached);
        if (!pressed) begin
            press_held = 1'b0;
            press_age  = '0;
            reached    = 1'b0;
        end else begin
            if (!press_held) begin
                press_held = 1'b1;
                press_age  = '0;
            end else begin
                press_age = inc_sat(press_age);
            end
            reached = (press_age >= need);
        end
    endtask

    // One millisecond tick of the sequencer; queues the result it should give
    task automatic advance_sequencer(input logic arm, input logic rst, input logic lau,
                                     input logic gf);
        logic         step;
        logic         hit;
        tick_result_t r;
        step        = 1'b0;
        hit         = 1'b0;
        entered_now = 1'b0;
        mode_age    = inc_sat(mode_age);

        if (cur_mode != MODE_FAULT && gf)
            enter(MODE_FAULT);

        case (cur_mode)
            MODE_STARTUP: begin
                if (arm || rst || lau) begin
                    enter(MODE_FAULT);
                end else begin
                    step_timer = inc_sat(step_timer);
                    if (steps_finished)
                        settle_timer = inc_sat(settle_timer);
                    if (step_timer >= limit_ms[CFG_CHECK_INTERVAL]) begin
                        step_timer = '0;
                        if (steps_shown < CHECK_COUNT) begin
                            steps_shown = steps_shown + 1'b1;
                            step        = 1'b1;
                        end else begin
                            if (!steps_finished) begin
                                steps_finished = 1'b1;
                                settle_timer   = '0;
                            end
                            if (settle_timer >= COMPLETE_WAIT_MS)
                                enter(MODE_READY);
                        end
                    end
                end
            end
            MODE_SPLASH: begin
                if (mode_age >= limit_ms[CFG_SPLASH])
                    enter(MODE_STARTUP);
            end
            MODE_READY: begin
                if (arm)
                    enter(MODE_ARMED);
            end
            MODE_ARMED: begin
                if (!arm) begin
                    enter(MODE_READY);
                end else begin
                    track_press(lau, limit_ms[CFG_LAUNCH_CONFIRM], hit);
                    if (hit)
                        enter(MODE_COUNTDOWN);
                end
            end
            MODE_COUNTDOWN: begin
                if (!arm)
                    enter(MODE_FAULT);
                else if (!lau)
                    enter(MODE_ABORT);
                else if (mode_age >= limit_ms[CFG_HOLD_TO_LAUNCH])
                    enter(MODE_LAUNCHING);
            end
            MODE_LAUNCHING: begin
                if (mode_age >= limit_ms[CFG_RELAY_ON])
                    enter(MODE_COOLDOWN);
            end
            MODE_COOLDOWN: begin
                if (mode_age >= limit_ms[CFG_COOLDOWN])
                    enter(MODE_FAULT);
            end
            MODE_ABORT: begin
                if (mode_age >= limit_ms[CFG_ABORT_INHIBIT])
                    enter(arm ? MODE_ARMED : MODE_READY);
            end
            MODE_FAULT: begin
                // Leaving fault needs arm off and reset held, with no global fault
                if (!arm) begin
                    track_press(rst, limit_ms[CFG_RESET_HOLD], hit);
                    if (hit && !gf)
                        enter(MODE_READY);
                end else begin
                    press_held = 1'b0;
                    press_age  = '0;
                end
            end
            default: begin
                enter(MODE_FAULT);
            end
        endcase

        r.mode         = cur_mode;
        r.ready_led    = (cur_mode == MODE_READY);
        r.armed_led    = (cur_mode == MODE_ARMED) || (cur_mode == MODE_COUNTDOWN);
        r.launch_lamp  = (cur_mode == MODE_LAUNCHING);
        r.relay_drive  = (cur_mode == MODE_LAUNCHING);
        r.check_step   = step;
        r.check_number = steps_shown;
        r.mode_entered = entered_now;
        due_results.push_back(r);
    endtask

    // Sample both channels and the write port on each edge
    always @(posedge aclk) begin
        tick_result_t want;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_wr_en)
                limit_ms[cfg_index] = cfg_wr_data;

            // Results first: a result always belongs to an earlier item
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result item with no item outstanding");
                end else begin
                    want = due_results.pop_front();
                    check_field("mode", 16'(m_mode), 16'(want.mode));
                    check_field("ready_led", 16'(m_ready_led), 16'(want.ready_led));
                    check_field("armed_led", 16'(m_armed_led), 16'(want.armed_led));
                    check_field("launch_lamp", 16'(m_launch_lamp), 16'(want.launch_lamp));
                    check_field("relay_drive", 16'(m_relay_drive), 16'(want.relay_drive));
                    check_field("check_step", 16'(m_check_step), 16'(want.check_step));
                    check_field("check_number", 16'(m_check_number),
                                16'(want.check_number));
                    check_field("mode_entered", 16'(m_mode_entered),
                                16'(want.mode_entered));
                end
            end

            if (s_valid && s_ready)
                advance_sequencer(s_arm_on, s_reset_pressed, s_launch_pressed,
                                  s_global_fault);
        end
        pending_count <= due_results.size();
    end

endmodule

@@ tb/sv/launch_interlock_sequencer_tb.sv @@
// Testbench top for the launch interlock sequencer: clock, reset, tick stimulus and verdict.
module launch_interlock_sequencer_tb;
    import lis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_COUNT = 20;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               cfg_wr_en        = 1'b0;
    logic [2:0]         cfg_index        = CFG_HOLD_TO_LAUNCH;
    logic [TIMER_W-1:0] cfg_wr_data      = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic               s_arm_on         = 1'b0;
    logic               s_reset_pressed  = 1'b0;
    logic               s_launch_pressed = 1'b0;
    logic               s_global_fault   = 1'b0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [3:0]         m_mode;
    logic               m_ready_led;
    logic               m_armed_led;
    logic               m_launch_lamp;
    logic               m_relay_drive;
    logic               m_check_step;
    logic [COUNT_W-1:0] m_check_number;
    logic               m_mode_entered;

    int chk_fails;
    int chk_pending;

    int send_idle_pct = 37;
    int recv_idle_pct = 88;

    // Timing register values for the next load
    logic [TIMER_W-1:0] timing [8];

    // Operator switch levels, held between ticks
    logic lv_arm = 1'b0;
    logic lv_rst = 1'b0;
    logic lv_lau = 1'b0;

    launch_interlock_sequencer #(.CHECK_COUNT(STEP_COUNT)) dut (.*);

    launch_sequence_checker #(.CHECK_COUNT(STEP_COUNT)) seq_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .s_valid, .s_ready, .s_arm_on, .s_reset_pressed, .s_launch_pressed,
        .s_global_fault, .m_valid, .m_ready, .m_mode, .m_ready_led, .m_armed_led,
        .m_launch_lamp, .m_relay_drive, .m_check_step, .m_check_number,
        .m_mode_entered, .fail_count(chk_fails), .pending_count(chk_pending)
    );

    always #4 aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one tick item, after a random gap, and wait for it to be taken
    task automatic send_tick(input logic arm, input logic rst, input logic lau,
                             input logic gf);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_arm_on         <= arm;
        s_reset_pressed  <= rst;
        s_launch_pressed <= lau;
        s_global_fault   <= gf;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_levels(input int n, input logic arm, input logic rst,
                               input logic lau, input logic gf);
        repeat (n) send_tick(arm, rst, lau, gf);
    endtask

    // Stop sending until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_timing();
        for (int i = 0; i < $size(timing); i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_index_t'(i);
            cfg_wr_data <= timing[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_short_timing();
        for (int i = 0; i < $size(timing); i++)
            timing[i] = 16'($urandom_range(6));
        timing[CFG_CHECK_INTERVAL] = 16'($urandom_range(4, 1));
    endtask

    // Mostly slow-moving operator levels, with some fully random ticks
    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8) begin
                lv_arm = 1'($urandom_range(1));
                lv_rst = 1'($urandom_range(1));
                lv_lau = 1'($urandom_range(1));
                send_tick(lv_arm, lv_rst, lv_lau, $urandom_range(3) == 0);
            end else begin
                if ($urandom_range(24) == 0)
                    lv_arm = ~lv_arm;
                if ($urandom_range(5) == 0)
                    lv_lau = ~lv_lau;
                if ($urandom_range(7) == 0)
                    lv_rst = ~lv_rst;
                send_tick(lv_arm, lv_rst, lv_lau, $urandom_range(59) == 0);
            end
            if ($urandom_range(99) == 0)
                drain();
        end
    endtask

    task automatic run_phase(input int count);
        drain();
        load_timing();
        run_random(count);
    endtask

    initial begin
        int interval;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short timers; zero splash leaves splash on the first tick
        timing[CFG_HOLD_TO_LAUNCH] = 16'd3;
        timing[CFG_RELAY_ON]       = 16'd2;
        timing[CFG_COOLDOWN]       = 16'd2;
        timing[CFG_ABORT_INHIBIT]  = 16'd2;
        timing[CFG_RESET_HOLD]     = 16'd3;
        timing[CFG_SPLASH]         = 16'd0;
        timing[CFG_CHECK_INTERVAL] = 16'($urandom_range(3, 1));
        timing[CFG_LAUNCH_CONFIRM] = 16'd2;
        load_timing();
        interval = int'(timing[CFG_CHECK_INTERVAL]);

        // Quiet ticks through splash, the self-check steps and the settle wait
        hold_levels(STEP_COUNT * interval + COMPLETE_WAIT_MS + 3 * interval + 10,
                    1'b0, 1'b0, 1'b0, 1'b0);

        // Full launch: arm, confirm, countdown, fire, cooldown into fault
        hold_levels(1, 1'b1, 1'b0, 1'b0, 1'b0);
        hold_levels(6, 1'b1, 1'b0, 1'b1, 1'b0);
        hold_levels(2, 1'b1, 1'b0, 1'b1, 1'b0);
        hold_levels(2, 1'b0, 1'b0, 1'b0, 1'b0);
        // Fault: reset ignored while armed, held with global fault, then clears
        hold_levels(1, 1'b1, 1'b1, 1'b0, 1'b0);
        hold_levels(1, 1'b0, 1'b1, 1'b0, 1'b1);
        hold_levels(4, 1'b0, 1'b1, 1'b0, 1'b0);
        // Early release aborts, inhibit runs out back to ready
        hold_levels(1, 1'b1, 1'b0, 1'b0, 1'b0);
        hold_levels(3, 1'b1, 1'b0, 1'b1, 1'b0);
        hold_levels(1, 1'b1, 1'b0, 1'b0, 1'b0);
        hold_levels(2, 1'b0, 1'b0, 1'b0, 1'b0);
        // Global fault from ready
        hold_levels(1, 1'b0, 1'b0, 1'b0, 1'b1);

        pick_short_timing();
        run_phase(40);

        // Long countdown and inhibit, instant relay and cooldown
        timing[CFG_HOLD_TO_LAUNCH] = 16'hFFFF;
        timing[CFG_RELAY_ON]       = 16'd0;
        timing[CFG_COOLDOWN]       = 16'd0;
        timing[CFG_ABORT_INHIBIT]  = 16'hFFFF;
        timing[CFG_RESET_HOLD]     = 16'd2;
        timing[CFG_SPLASH]         = 16'hFFFF;
        timing[CFG_CHECK_INTERVAL] = 16'hFFFF;
        timing[CFG_LAUNCH_CONFIRM] = 16'd0;
        run_phase(40);

        send_idle_pct = 88;
        recv_idle_pct = 37;
        pick_short_timing();
        run_phase(40);

        // Relay and cooldown that only a global fault ends
        timing[CFG_HOLD_TO_LAUNCH] = 16'd0;
        timing[CFG_RELAY_ON]       = 16'hFFFF;
        timing[CFG_COOLDOWN]       = 16'hFFFF;
        timing[CFG_ABORT_INHIBIT]  = 16'd0;
        timing[CFG_RESET_HOLD]     = 16'd0;
        timing[CFG_SPLASH]         = 16'd0;
        timing[CFG_CHECK_INTERVAL] = 16'd1;
        timing[CFG_LAUNCH_CONFIRM] = 16'd0;
        run_phase(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Fault and armed that cannot be completed
        pick_short_timing();
        timing[CFG_RESET_HOLD]     = 16'hFFFF;
        timing[CFG_LAUNCH_CONFIRM] = 16'hFFFF;
        run_phase(40);

        pick_short_timing();
        run_phase(50);

        drain();
        repeat (10) @(posedge aclk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ launch_interlock_sequencer.f @@
design/lis_pkg.sv
design/launch_interlock_sequencer.sv
tb/sv/launch_sequence_checker.sv
tb/sv/launch_interlock_sequencer_tb.sv
